[rtl/sirm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sirm_pkg
// Shared types and constants for the inverse stereographic remap block.
// ----------------------------------------------------------------------------
package sirm_pkg;

	localparam int SCALE_W   = 24;
	localparam int IN_W      = 16;
	localparam int OUT_W     = 24;
	localparam int ROW_W     = 63;
	localparam int INT_BITS  = 15;
	localparam int FRAC_BITS = 9;
	localparam int QW        = INT_BITS + FRAC_BITS;
	localparam int APB_DW    = 64;
	localparam int APB_AW    = 5;
	localparam int REG_LSB   = 3;

	localparam logic signed [OUT_W-1:0] OUT_MAX    = 24'sh7FFFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN    = 24'sh800000;
	localparam logic signed [OUT_W-1:0] NEG_ONE_Q8 = -24'sd256;
	localparam logic [SCALE_W-1:0]      SCALE_RST  = 24'd256;

	typedef enum logic [APB_AW-REG_LSB-1:0] {
		REG_SCALE,
		REG_ROW_X,
		REG_ROW_Y,
		REG_ROW_Z
	} reg_idx_t;

endpackage
`default_nettype wire

[rtl/stereographic_inverse_remap_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stereographic_inverse_remap_top
// Inverse stereographic remap: destination pixel in, source coordinate out.
// ----------------------------------------------------------------------------
// One destination word is taken per clock unless a stall on the result side
// has filled the pipeline. 2 stages build the ray, 3 stages form the matrix product
// (split multiplies, recombine, row sums) and 26 stages divide, of which
// 24 produce one quotient bit each for X/Z and Y/Z in parallel. Stalls on
// the result side back up stage by stage, so empty stages keep filling.
// Registers sit on an APB port at byte addresses 0, 8, 16 and 24.
module stereographic_inverse_remap_top #(
	parameter int COORD_BITS = 16,
	parameter int COEF_BITS  = 21
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [sirm_pkg::APB_AW-1:0]        paddr,
	input  wire logic [sirm_pkg::APB_DW-1:0]        pwdata,
	output logic [sirm_pkg::APB_DW-1:0]             prdata,
	output logic                                    pready,
	input  wire logic                               dest_valid,
	output logic                                    dest_ready,
	input  wire logic signed [sirm_pkg::IN_W-1:0]   dest_u,
	input  wire logic signed [sirm_pkg::IN_W-1:0]   dest_v,
	output logic                                    source_valid,
	input  wire logic                               source_ready,
	output logic signed [sirm_pkg::OUT_W-1:0]       source_x,
	output logic signed [sirm_pkg::OUT_W-1:0]       source_y,
	output logic                                    in_front
);
	import sirm_pkg::*;

	localparam int DA = 2 * COORD_BITS + 10;
	localparam int DB = SCALE_W + COORD_BITS + 2;
	localparam int DM = (DA > DB) ? DA : DB;
	localparam int DW = (DM > 2 * SCALE_W - 6) ? DM : 2 * SCALE_W - 6;
	localparam int PW = COEF_BITS + DW + 2;

	logic [SCALE_W-1:0] scale_q;
	logic [ROW_W-1:0]   row_x_q, row_y_q, row_z_q;
	logic               wr_en;
	reg_idx_t           idx;

	logic                 ray_valid, ray_ready, prj_valid, prj_ready;
	logic signed [DW-1:0] d0, d1, d2;
	logic signed [PW-1:0] px, py, pz;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[APB_AW-1:REG_LSB]);
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
			row_x_q <= '0;
			row_y_q <= '0;
			row_z_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_SCALE: scale_q <= pwdata[SCALE_W-1:0];
				REG_ROW_X: row_x_q <= pwdata[ROW_W-1:0];
				REG_ROW_Y: row_y_q <= pwdata[ROW_W-1:0];
				REG_ROW_Z: row_z_q <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SCALE: prdata = APB_DW'(scale_q);
			REG_ROW_X: prdata = APB_DW'(row_x_q);
			REG_ROW_Y: prdata = APB_DW'(row_y_q);
			REG_ROW_Z: prdata = APB_DW'(row_z_q);
			default:   prdata = '0;
		endcase
	end

	sirm_ray #(.COORD_BITS(COORD_BITS), .DW(DW)) u_ray (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dest_valid),
		.in_ready  (dest_ready),
		.dest_u    (dest_u),
		.dest_v    (dest_v),
		.scale_q8  (scale_q),
		.out_valid (ray_valid),
		.out_ready (ray_ready),
		.d0        (d0),
		.d1        (d1),
		.d2        (d2)
	);

	sirm_proj #(.COEF_BITS(COEF_BITS), .DW(DW), .PW(PW)) u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ray_valid),
		.in_ready  (ray_ready),
		.d0        (d0),
		.d1        (d1),
		.d2        (d2),
		.row_x     (row_x_q),
		.row_y     (row_y_q),
		.row_z     (row_z_q),
		.out_valid (prj_valid),
		.out_ready (prj_ready),
		.x         (px),
		.y         (py),
		.z         (pz)
	);

	sirm_div #(.PW(PW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prj_valid),
		.in_ready  (prj_ready),
		.x         (px),
		.y         (py),
		.z         (pz),
		.out_valid (source_valid),
		.out_ready (source_ready),
		.source_x  (source_x),
		.source_y  (source_y),
		.in_front  (in_front)
	);

`ifndef SYNTHESIS
	a_behind_default: assert property (@(posedge clk) disable iff (!arst_n)
		source_valid && !in_front |-> source_x == NEG_ONE_Q8 && source_y == NEG_ONE_Q8)
		else $error("behind-camera word not at default");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!source_valid |-> dest_ready)
		else $error("empty output stage but input stalled");

	a_scale_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && idx == REG_SCALE |=> scale_q == $past(pwdata[SCALE_W-1:0]))
		else $error("scale register write lost");
`endif

endmodule
`default_nettype wire

[rtl/sirm_ray.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sirm_ray
// Two-stage ray builder: (2sV, s^2 - U^2 - V^2, 2sU) in Q.8 units.
// ----------------------------------------------------------------------------
module sirm_ray #(
	parameter int COORD_BITS = 16,
	parameter int DW = 42
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [sirm_pkg::IN_W-1:0]  dest_u,
	input  wire logic signed [sirm_pkg::IN_W-1:0]  dest_v,
	input  wire logic [sirm_pkg::SCALE_W-1:0]      scale_q8,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [DW-1:0]                   d0,
	output logic signed [DW-1:0]                   d1,
	output logic signed [DW-1:0]                   d2
);
	import sirm_pkg::*;

	localparam int CW = COORD_BITS;
	localparam int SPW = SCALE_W + 1 + CW;

	logic signed [CW-1:0]        u_c, v_c;
	logic signed [SCALE_W:0]     s_c;
	logic signed [SPW-1:0]       su_c, sv_c;
	logic signed [2*CW-1:0]      uu_c, vv_c;
	logic [2*SCALE_W-1:0]        ss_c;
	logic                        vld_s1, vld_s2, en1, en2;
	logic signed [SPW-1:0]       su_s1, sv_s1;
	logic signed [2*CW-1:0]      uu_s1, vv_s1;
	logic [2*SCALE_W-1:0]        ss_s1;
	logic [2*CW:0]               r2_c;
	logic signed [DW-1:0]        d0_c, d1_c, d2_c;

	generate
		if (CW <= IN_W) begin : g_narrow
			assign u_c = dest_u[CW-1:0];
			assign v_c = dest_v[CW-1:0];
		end else begin : g_wide
			assign u_c = $signed({{(CW-IN_W){1'b0}}, dest_u});
			assign v_c = $signed({{(CW-IN_W){1'b0}}, dest_v});
		end
	endgenerate

	assign s_c  = $signed({1'b0, scale_q8});
	assign su_c = s_c * u_c;
	assign sv_c = s_c * v_c;
	assign uu_c = u_c * u_c;
	assign vv_c = v_c * v_c;
	assign ss_c = scale_q8 * scale_q8;

	assign en2      = ~vld_s2 | out_ready;
	assign en1      = ~vld_s1 | en2;
	assign in_ready = en1;
	assign out_valid = vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			su_s1 <= su_c;
			sv_s1 <= sv_c;
			uu_s1 <= uu_c;
			vv_s1 <= vv_c;
			ss_s1 <= ss_c;
		end
	end

	assign r2_c = {1'b0, $unsigned(uu_s1)} + {1'b0, $unsigned(vv_s1)};
	assign d0_c = DW'(sv_s1) <<< 1;
	assign d2_c = DW'(su_s1) <<< 1;
	assign d1_c = $signed(DW'(ss_s1 >> 8)) - $signed(DW'({r2_c, 8'b0}));

	always_ff @(posedge clk) begin
		if (en2) begin
			d0 <= d0_c;
			d1 <= d1_c;
			d2 <= d2_c;
		end
	end

endmodule
`default_nettype wire

[rtl/sirm_proj.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sirm_proj
// Three-stage 3x3 matrix times ray: split products, recombine, row sums.
// ----------------------------------------------------------------------------
module sirm_proj #(
	parameter int COEF_BITS = 21,
	parameter int DW = 42,
	parameter int PW = 65
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [DW-1:0]          d0,
	input  wire logic signed [DW-1:0]          d1,
	input  wire logic signed [DW-1:0]          d2,
	input  wire logic [sirm_pkg::ROW_W-1:0]    row_x,
	input  wire logic [sirm_pkg::ROW_W-1:0]    row_y,
	input  wire logic [sirm_pkg::ROW_W-1:0]    row_z,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [PW-1:0]               x,
	output logic signed [PW-1:0]               y,
	output logic signed [PW-1:0]               z
);
	import sirm_pkg::*;

	localparam int L   = DW / 2;
	localparam int LOW = COEF_BITS + L + 1;
	localparam int HIW = COEF_BITS + DW - L;

	logic [ROW_W-1:0]             rows [3];
	logic signed [DW-1:0]         dd   [3];
	logic signed [COEF_BITS-1:0]  cf   [3][3];
	logic signed [LOW-1:0]        plo_s3 [3][3];
	logic signed [HIW-1:0]        phi_s3 [3][3];
	logic signed [PW-1:0]         p_s4   [3][3];
	logic                         vld_s3, vld_s4, vld_s5, en3, en4, en5;

	assign rows[0] = row_x;
	assign rows[1] = row_y;
	assign rows[2] = row_z;
	assign dd[0] = d0;
	assign dd[1] = d1;
	assign dd[2] = d2;

	assign en5 = ~vld_s5 | out_ready;
	assign en4 = ~vld_s4 | en5;
	assign en3 = ~vld_s3 | en4;
	assign in_ready  = en3;
	assign out_valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en3) vld_s3 <= in_valid;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar k = 0; k < 3; k++) begin : g_col
			assign cf[r][k] = $signed(rows[r][k*COEF_BITS +: COEF_BITS]);

			always_ff @(posedge clk) begin
				if (en3) begin
					plo_s3[r][k] <= cf[r][k] * $signed({1'b0, dd[k][L-1:0]});
					phi_s3[r][k] <= cf[r][k] * $signed(dd[k][DW-1:L]);
				end
				if (en4) begin
					p_s4[r][k] <= (PW'(phi_s3[r][k]) <<< L) + PW'(plo_s3[r][k]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			x <= p_s4[0][0] + p_s4[0][1] + p_s4[0][2];
			y <= p_s4[1][0] + p_s4[1][1] + p_s4[1][2];
			z <= p_s4[2][0] + p_s4[2][1] + p_s4[2][2];
		end
	end

endmodule
`default_nettype wire

[rtl/sirm_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sirm_div
// Pipelined restoring divider for X/Z and Y/Z, one quotient bit per stage,
// with round to nearest, saturation and the behind-camera default.
// ----------------------------------------------------------------------------
module sirm_div #(
	parameter int PW = 65
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [PW-1:0]                x,
	input  wire logic signed [PW-1:0]                y,
	input  wire logic signed [PW-1:0]                z,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [sirm_pkg::OUT_W-1:0]        source_x,
	output logic signed [sirm_pkg::OUT_W-1:0]        source_y,
	output logic                                     in_front
);
	import sirm_pkg::*;

	localparam int RW = PW + QW;
	localparam int SW = PW + INT_BITS;
	localparam int NS = QW + 2;

	logic [PW-1:0]  ax_c, ay_c, zu_c;
	logic           vld_s [NS];
	logic           en    [NS+1];
	logic [RW-1:0]  rx_s  [QW+1];
	logic [RW-1:0]  ry_s  [QW+1];
	logic [QW-1:0]  qx_s  [QW+1];
	logic [QW-1:0]  qy_s  [QW+1];
	logic [PW-1:0]  z_s   [QW+1];
	logic           fr_s  [QW+1];
	logic           nx_s  [QW+1];
	logic           ny_s  [QW+1];
	logic           sx_s  [QW+1];
	logic           sy_s  [QW+1];
	logic [QW:0]    mx_c, my_c;
	logic signed [OUT_W-1:0] ox_c, oy_c;

	assign en[NS] = out_ready;
	for (genvar i = 0; i < NS; i++) begin : g_en
		logic vld_prev;

		if (i == 0) begin : g_head
			assign vld_prev = in_valid;
		end else begin : g_tail
			assign vld_prev = vld_s[i-1];
		end

		assign en[i] = ~vld_s[i] | en[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en[i]) begin
				vld_s[i] <= vld_prev;
			end
		end
	end
	assign in_ready  = en[0];
	assign out_valid = vld_s[NS-1];

	assign ax_c = $unsigned(x < 0 ? -x : x);
	assign ay_c = $unsigned(y < 0 ? -y : y);
	assign zu_c = $unsigned(z);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rx_s[0] <= RW'(ax_c) << FRAC_BITS;
			ry_s[0] <= RW'(ay_c) << FRAC_BITS;
			qx_s[0] <= '0;
			qy_s[0] <= '0;
			z_s[0]  <= zu_c;
			fr_s[0] <= (z > 0);
			nx_s[0] <= x[PW-1];
			ny_s[0] <= y[PW-1];
			sx_s[0] <= SW'(ax_c) >= (SW'(zu_c) << INT_BITS);
			sy_s[0] <= SW'(ay_c) >= (SW'(zu_c) << INT_BITS);
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_bit
		localparam int B = QW - 1 - j;
		logic [RW-1:0] dsh_c;
		logic          gx_c, gy_c;

		assign dsh_c = RW'(z_s[j]) << B;
		assign gx_c  = rx_s[j] >= dsh_c;
		assign gy_c  = ry_s[j] >= dsh_c;

		always_ff @(posedge clk) begin
			if (en[j+1]) begin
				rx_s[j+1]    <= gx_c ? rx_s[j] - dsh_c : rx_s[j];
				ry_s[j+1]    <= gy_c ? ry_s[j] - dsh_c : ry_s[j];
				qx_s[j+1]    <= qx_s[j] | (QW'(gx_c) << B);
				qy_s[j+1]    <= qy_s[j] | (QW'(gy_c) << B);
				z_s[j+1]     <= z_s[j];
				fr_s[j+1]    <= fr_s[j];
				nx_s[j+1]    <= nx_s[j];
				ny_s[j+1]    <= ny_s[j];
				sx_s[j+1]    <= sx_s[j];
				sy_s[j+1]    <= sy_s[j];
			end
		end
	end

	assign mx_c = ({1'b0, qx_s[QW]} + (QW+1)'(1)) >> 1;
	assign my_c = ({1'b0, qy_s[QW]} + (QW+1)'(1)) >> 1;

	always_comb begin
		if (!fr_s[QW]) begin
			ox_c = NEG_ONE_Q8;
		end else if (sx_s[QW] || mx_c[QW] || mx_c[QW-1]) begin
			ox_c = nx_s[QW] ? OUT_MIN : OUT_MAX;
		end else begin
			ox_c = nx_s[QW] ? -$signed(mx_c[OUT_W-1:0]) : $signed(mx_c[OUT_W-1:0]);
		end
		if (!fr_s[QW]) begin
			oy_c = NEG_ONE_Q8;
		end else if (sy_s[QW] || my_c[QW] || my_c[QW-1]) begin
			oy_c = ny_s[QW] ? OUT_MIN : OUT_MAX;
		end else begin
			oy_c = ny_s[QW] ? -$signed(my_c[OUT_W-1:0]) : $signed(my_c[OUT_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			source_x <= ox_c;
			source_y <= oy_c;
			in_front <= fr_s[QW];
		end
	end

endmodule
`default_nettype wire

[tb/sv/stereographic_inverse_remap_top_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereographic_inverse_remap_top_tb
// Streams destination pixels through the remap block under several scale and
// camera matrix settings, predicts each source coordinate in the bench and
// compares every result word field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module stereographic_inverse_remap_top_tb;
	import sirm_pkg::*;

	localparam int COEF = 21;
	localparam int PIPE_LAT = 40;

	typedef struct packed {
		logic signed [IN_W-1:0] u;
		logic signed [IN_W-1:0] v;
	} pixel_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic                    front;
	} coord_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic dest_valid = 1'b0;
	logic dest_ready;
	logic signed [IN_W-1:0] dest_u = '0, dest_v = '0;
	logic source_valid;
	logic source_ready = 1'b0;
	logic signed [OUT_W-1:0] source_x, source_y;
	logic in_front;

	stereographic_inverse_remap_top u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [SCALE_W-1:0] cur_scale;
	logic [ROW_W-1:0] cur_row [3];
	pixel_t pixel_q [$];
	coord_t coord_q [$];
	int fail_cnt = 0;
	bit calm = 1'b0;
	int src_gap = 0, snk_gap = 0;

	function automatic longint coef_of(logic [ROW_W-1:0] row, int k);
		logic signed [COEF-1:0] c;
		c = row[k*COEF +: COEF];
		return longint'(c);
	endfunction

	function automatic logic signed [OUT_W-1:0] quot_q8(longint num, longint den);
		logic [63:0] a, z, qi, r, q, m;
		bit neg;
		neg = num < 0;
		a = neg ? -num : num;
		z = den;
		qi = a / z;
		r = a % z;
		if (qi >= 64'd32768) return neg ? OUT_MIN : OUT_MAX;
		q = qi;
		for (int i = 0; i < 9; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= z) begin
				r = r - z;
				q[0] = 1'b1;
			end
		end
		m = (q + 1) >> 1;
		if (neg) return (m >= 64'd8388608) ? OUT_MIN : OUT_W'(-longint'(m));
		return (m > 64'd8388607) ? OUT_MAX : OUT_W'(m);
	endfunction

	function automatic coord_t remap(pixel_t p);
		longint u, v, s, d [3], acc [3];
		coord_t c;
		u = p.u;
		v = p.v;
		s = cur_scale;
		d[0] = 2 * s * v;
		d[1] = ((s * s) >>> 8) - ((u * u + v * v) <<< 8);
		d[2] = 2 * s * u;
		for (int r = 0; r < 3; r++)
			acc[r] = coef_of(cur_row[r], 0) * d[0] + coef_of(cur_row[r], 1) * d[1]
				+ coef_of(cur_row[r], 2) * d[2];
		if (acc[2] > 0) begin
			c.x = quot_q8(acc[0], acc[2]);
			c.y = quot_q8(acc[1], acc[2]);
			c.front = 1'b1;
		end else begin
			c.x = NEG_ONE_Q8;
			c.y = NEG_ONE_Q8;
			c.front = 1'b0;
		end
		return c;
	endfunction

	// driver
	always @(posedge clk) begin
		if (dest_valid && dest_ready) begin
			coord_q.push_back(remap(pixel_q.pop_front()));
		end
		if (!dest_valid || dest_ready) begin
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				dest_valid <= 1'b0;
			end else if (pixel_q.size() > 0) begin
				if (!calm && $urandom_range(0, 9) == 0) begin
					src_gap <= $urandom_range(1, 16) - 1;
					dest_valid <= 1'b0;
				end else begin
					dest_valid <= 1'b1;
					dest_u <= pixel_q[0].u;
					dest_v <= pixel_q[0].v;
				end
			end else begin
				dest_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		coord_t want;
		if (source_valid && source_ready) begin
			if (coord_q.size() == 0) begin
				$display("%0t unexpected word x=%0d y=%0d f=%0b", $time, source_x,
					source_y, in_front);
				fail_cnt++;
			end else begin
				want = coord_q.pop_front();
				if (want.x !== source_x) begin
					$display("%0t x mismatch exp %0d act %0d", $time, want.x, source_x);
					fail_cnt++;
				end
				if (want.y !== source_y) begin
					$display("%0t y mismatch exp %0d act %0d", $time, want.y, source_y);
					fail_cnt++;
				end
				if (want.front !== in_front) begin
					$display("%0t in_front mismatch exp %0b act %0b", $time, want.front,
						in_front);
					fail_cnt++;
				end
			end
		end
		if (snk_gap > 0) begin
			snk_gap <= snk_gap - 1;
			source_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			snk_gap <= $urandom_range(1, 16) - 1;
			source_ready <= 1'b0;
		end else begin
			source_ready <= 1'b1;
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [APB_DW-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(idx) << REG_LSB;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SCALE: cur_scale = val[SCALE_W-1:0];
			REG_ROW_X: cur_row[0] = val[ROW_W-1:0];
			REG_ROW_Y: cur_row[1] = val[ROW_W-1:0];
			default:   cur_row[2] = val[ROW_W-1:0];
		endcase
	endtask

	task automatic drain();
		while (pixel_q.size() > 0 || dest_valid || coord_q.size() > 0) @(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	function automatic logic [ROW_W-1:0] pack_row(int c0, int c1, int c2);
		return {COEF'(c2), COEF'(c1), COEF'(c0)};
	endfunction

	task automatic push_pixel(int u, int v);
		pixel_t p;
		p.u = IN_W'(u);
		p.v = IN_W'(v);
		pixel_q.push_back(p);
	endtask

	task automatic push_random(int n, int span);
		for (int i = 0; i < n; i++)
			if (span == 0) push_pixel($urandom, $urandom);
			else push_pixel($urandom_range(0, 2 * span) - span,
				$urandom_range(0, 2 * span) - span);
	endtask

	function automatic logic [ROW_W-1:0] rand_row();
		return ROW_W'({$urandom, $urandom});
	endfunction

	initial begin
		cur_scale = SCALE_RST;
		cur_row[0] = '0;
		cur_row[1] = '0;
		cur_row[2] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// all-zero matrix: never in front
		push_pixel(0, 0);
		push_pixel(32767, -32768);
		push_pixel(-1, 1);
		drain();

		// identity-like camera, scale 1.0
		reg_write(REG_SCALE, 64'd256);
		reg_write(REG_ROW_X, pack_row(1024, 0, 0));
		reg_write(REG_ROW_Y, pack_row(0, 0, 1024));
		reg_write(REG_ROW_Z, pack_row(0, 1024, 0));
		push_pixel(0, 0);
		push_pixel(1, 0);
		push_pixel(0, 1);
		push_pixel(-1, -1);
		push_pixel(32767, 32767);
		push_pixel(-32768, -32768);
		push_pixel(32767, -32768);
		push_pixel(0, -32768);
		drain();

		// scale zero and extreme coefficients
		reg_write(REG_SCALE, 64'd0);
		reg_write(REG_ROW_Z, pack_row(0, -1048576, 0));
		reg_write(REG_ROW_X, pack_row(1048575, -1048576, 1048575));
		push_pixel(0, 0);
		push_pixel(5, 3);
		push_pixel(-32768, 32767);
		drain();

		// maximum scale, upper bits of row words set
		reg_write(REG_SCALE, 64'hFFFFFFFF_FFFFFFFF);
		reg_write(REG_ROW_Z, {1'b1, pack_row(3, 1024, -7)});
		reg_write(REG_ROW_Y, 64'h7FFF_FFFF_FFFF_FFFF);
		push_pixel(0, 0);
		push_pixel(1, 1);
		push_pixel(32767, 0);
		push_pixel(-32768, -1);
		push_random(4, 0);
		drain();

		// random settings, mostly modest coordinates so results land in front
		for (int ph = 0; ph < 8; ph++) begin
			reg_write(REG_SCALE, ph[0] ? $urandom_range(256, 1 << 16) : $urandom);
			reg_write(REG_ROW_X, ph < 2 ? rand_row()
				: pack_row($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048,
					$urandom_range(0, 4096) - 2048));
			reg_write(REG_ROW_Y, rand_row());
			reg_write(REG_ROW_Z, ph < 2 ? rand_row()
				: pack_row($urandom_range(0, 64) - 32, $urandom_range(256, 2048),
					$urandom_range(0, 64) - 32));
			if (ph == 7) calm = 1'b1;
			push_random(60, 0);
			push_random(100, ph < 4 ? 255 : 2047);
			push_random(15, 15);
			drain();
		end

		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
rtl/sirm_pkg.sv
rtl/sirm_ray.sv
rtl/sirm_proj.sv
rtl/sirm_div.sv
rtl/stereographic_inverse_remap_top.sv
tb/sv/stereographic_inverse_remap_top_tb.sv
